/* design/rlec_pkg.sv */
// ----------------------------------------------------------------------------
// rlec_pkg
// Shared types and codes for the reference-counted LRU entry cache.
// ----------------------------------------------------------------------------
package rlec_pkg;

    localparam int SLOT_IDX_W = 8;   // wide enough for the largest table
    localparam int KEY_W      = 32;
    localparam int AGE_W      = 32;
    localparam int RCNT_W     = 31;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_CREATE_NG = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_PRESENT   = 3'd4;
    localparam logic [2:0] ST_ABSENT    = 3'd5;
    localparam logic [2:0] ST_RELEASED  = 3'd6;
    localparam logic [2:0] ST_REL_EMPTY = 3'd7;

    localparam logic [4:0] SIZE_LIMIT_RST = 5'd16;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic             create_ok;
        logic [3:0]       handle;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] handle_out;
        logic [4:0] evicted_count;
    } t_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_ADDREF,
        OP_RELEASE,
        OP_EVICT
    } t_op;

    // Command broadcast to every cell.
    typedef struct packed {
        t_op                    op;
        logic [SLOT_IDX_W-1:0]  idx;
        logic [KEY_W-1:0]       key;
        logic signed [AGE_W-1:0] stamp;
    } t_cell_cmd;

    // Search packet that moves one cell per cycle.
    typedef struct packed {
        logic                    active;
        logic                    match_found;
        logic [SLOT_IDX_W-1:0]   match_idx;
        logic                    free_found;
        logic [SLOT_IDX_W-1:0]   free_idx;
        logic                    vic_found;
        logic [SLOT_IDX_W-1:0]   vic_idx;
        logic signed [AGE_W-1:0] vic_age;
        logic                    h_valid;
        logic                    h_le1;
    } t_pkt;

endpackage

/* design/refcounted_lru_entry_cache.sv */
// ----------------------------------------------------------------------------
// refcounted_lru_entry_cache
// Keyed entry table with reference counts and least-recently-released
// eviction, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Input channel: i_valid/i_data, this block drives o_stall. A transaction is
// taken when i_valid is high and o_stall is low; o_stall is high while a
// transaction is being worked on. Output channel: o_valid/o_data, the
// receiver drives i_stall. Every input transaction gives one output
// transaction.
// Each command sends a search packet down the cell chain, one cell a cycle.
// A hit, release or query goes from the sweep straight to the finish state,
// which raises o_valid; the block then returns to idle for the next
// transaction. An insert passes through a check state first; every eviction
// adds another sweep and check, and a sweep that finds no victim ends it.
// A result waiting in the output register does not stop the next
// transaction from being taken; only the final hand-off waits for it.
// The user writes size_limit via i_cfg_we/i_cfg_data only while idle (unenforced).
// Reset (synchronous, i_rst_n low) empties the table, clears the entry and
// release counters and sets size_limit to 16.
// ----------------------------------------------------------------------------
module refcounted_lru_entry_cache import rlec_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in        i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_out       o_data,
    input  logic       i_stall,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);

    localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [RCNT_W-1:0] RCNT_MAX = {RCNT_W{1'b1}};

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_CHECK, S_FINISH} t_state;

    t_state            r_state;
    t_in               r_req;
    t_cell_cmd         r_cmd;
    logic              r_inj;
    logic              r_evicting;
    logic [CW-1:0]     r_count;
    logic [RCNT_W-1:0] r_rcnt;
    logic [4:0]        r_limit;
    logic [4:0]        r_evicted;
    t_out              r_res;
    logic              r_ovalid;
    t_out              r_odata;

    t_pkt              w_pkt [CAPACITY+1];
    t_pkt              w_last;
    logic [RCNT_W-1:0] w_rcnt_next;
    logic              w_accept;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_last   = w_pkt[CAPACITY];
    assign w_rcnt_next = (r_rcnt == RCNT_MAX) ? r_rcnt : r_rcnt + 1'b1;

    always_comb begin
        w_pkt[0]        = '0;
        w_pkt[0].active = r_inj;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rlec_cell #(.IDX(g), .KW(KW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (r_cmd),
            .i_pkt  (w_pkt[g]),
            .o_pkt  (w_pkt[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmd.op   <= OP_NONE;
            r_inj      <= 1'b0;
            r_evicting <= 1'b0;
            r_count    <= '0;
            r_rcnt     <= '0;
            r_limit    <= SIZE_LIMIT_RST;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (r_state == S_FINISH && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
                r_odata  <= '{status: r_res.status, handle_out: r_res.handle_out,
                              evicted_count: r_evicted};
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cmd.op <= OP_NONE;
                    r_inj    <= w_accept;
                    if (w_accept) begin
                        r_req      <= i_data;
                        r_cmd.key  <= i_data.key;
                        r_cmd.idx  <= SLOT_IDX_W'(i_data.handle);
                        r_evicting <= 1'b0;
                        r_evicted  <= '0;
                        r_res      <= '0;
                        r_state    <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_inj <= 1'b0;
                    if (!w_last.active) begin
                        r_cmd.op <= OP_NONE;
                    end else if (r_evicting) begin
                        if (w_last.vic_found) begin
                            r_cmd.op  <= OP_EVICT;
                            r_cmd.idx <= w_last.vic_idx;
                            r_count   <= r_count - 1'b1;
                            r_evicted <= r_evicted + 1'b1;
                            r_state   <= S_CHECK;
                        end else begin
                            r_cmd.op <= OP_NONE;
                            r_state  <= S_FINISH;
                        end
                    end else if (r_req.cmd == CMD_GET) begin
                        if (w_last.match_found) begin
                            r_cmd.op         <= OP_ADDREF;
                            r_cmd.idx        <= w_last.match_idx;
                            r_res.status     <= ST_HIT;
                            r_res.handle_out <= w_last.match_idx[3:0];
                            r_state          <= S_FINISH;
                        end else if (!r_req.create_ok) begin
                            r_cmd.op     <= OP_NONE;
                            r_res.status <= ST_CREATE_NG;
                            r_state      <= S_FINISH;
                        end else if (!w_last.free_found) begin
                            r_cmd.op     <= OP_NONE;
                            r_res.status <= ST_FULL;
                            r_state      <= S_FINISH;
                        end else begin
                            r_cmd.op         <= OP_INSERT;
                            r_cmd.idx        <= w_last.free_idx;
                            r_count          <= r_count + 1'b1;
                            r_res.status     <= ST_INSERTED;
                            r_res.handle_out <= w_last.free_idx[3:0];
                            r_state          <= S_CHECK;
                        end
                    end else if (r_req.cmd == CMD_RELEASE) begin
                        r_res.handle_out <= r_req.handle;
                        r_state          <= S_FINISH;
                        if (w_last.h_valid) begin
                            r_cmd.op     <= OP_RELEASE;
                            r_cmd.stamp  <= -$signed({1'b0, w_rcnt_next});
                            r_res.status <= ST_RELEASED;
                            if (w_last.h_le1) r_rcnt <= w_rcnt_next;
                        end else begin
                            r_cmd.op     <= OP_NONE;
                            r_res.status <= ST_REL_EMPTY;
                        end
                    end else begin
                        r_cmd.op <= OP_NONE;
                        r_state  <= S_FINISH;
                        if (w_last.match_found) begin
                            r_res.status     <= ST_PRESENT;
                            r_res.handle_out <= w_last.match_idx[3:0];
                        end else begin
                            r_res.status <= ST_ABSENT;
                        end
                    end
                end
                S_CHECK: begin
                    // The update from the last search lands in the cells this cycle.
                    r_cmd.op <= OP_NONE;
                    if (CMPW'(r_count) > CMPW'(r_limit)) begin
                        r_evicting <= 1'b1;
                        r_inj      <= 1'b1;
                        r_state    <= S_SWEEP;
                    end else begin
                        r_inj   <= 1'b0;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_cmd.op <= OP_NONE;
                    r_inj    <= 1'b0;
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

/* design/rlec_cell.sv */
// ----------------------------------------------------------------------------
// rlec_cell
// One table slot: holds valid, key and age, folds itself into the passing
// search packet and applies broadcast updates addressed to it.
// ----------------------------------------------------------------------------
module rlec_cell import rlec_pkg::*; #(
    parameter int IDX = 0,
    parameter int KW  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_pkt      i_pkt,
    output t_pkt      o_pkt
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);
    localparam logic signed [AGE_W-1:0] AGE_MAX = 32'sh7fffffff;

    logic                    r_valid;
    logic [KW-1:0]           r_key;
    logic signed [AGE_W-1:0] r_age;
    t_pkt                    r_pkt;
    t_pkt                    n_pkt;
    logic                    w_sel;

    assign w_sel = (i_cmd.idx == MY_IDX);

    always_comb begin
        n_pkt = i_pkt;
        if (!n_pkt.match_found && r_valid && r_key == i_cmd.key[KW-1:0]) begin
            n_pkt.match_found = 1'b1;
            n_pkt.match_idx   = MY_IDX;
        end
        if (!n_pkt.free_found && !r_valid) begin
            n_pkt.free_found = 1'b1;
            n_pkt.free_idx   = MY_IDX;
        end
        // Strictly greater keeps the lowest slot on a tie.
        if (r_valid && r_age <= 0 && (!i_pkt.vic_found || i_pkt.vic_age < r_age)) begin
            n_pkt.vic_found = 1'b1;
            n_pkt.vic_idx   = MY_IDX;
            n_pkt.vic_age   = r_age;
        end
        if (w_sel) begin
            n_pkt.h_valid = r_valid;
            n_pkt.h_le1   = (r_age <= 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pkt.active <= 1'b0;
        end else begin
            r_pkt <= i_pkt.active ? n_pkt : i_pkt;
            if (w_sel) begin
                unique case (i_cmd.op)
                    OP_INSERT: begin
                        r_valid <= 1'b1;
                        r_key   <= i_cmd.key[KW-1:0];
                        r_age   <= 32'sd1;
                    end
                    OP_ADDREF: begin
                        if (r_age > 0) begin
                            if (r_age != AGE_MAX) r_age <= r_age + 32'sd1;
                        end else begin
                            r_age <= 32'sd1;
                        end
                    end
                    OP_RELEASE: begin
                        if (r_age > 1) r_age <= r_age - 32'sd1;
                        else           r_age <= i_cmd.stamp;
                    end
                    OP_EVICT: r_valid <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    assign o_pkt = r_pkt;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives cache requests into the reference-counted LRU entry cache, predicts
// each response from a behavioral copy of the table and checks every field.
// ----------------------------------------------------------------------------
module testbench;
    import rlec_pkg::*;

    localparam int NSLOT     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 900;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in        in_data = '0;
    logic       in_stall_dut;
    logic       out_valid;
    t_out       out_data;
    logic       out_stall = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_data = '0;

    refcounted_lru_entry_cache dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_data(in_data), .o_stall(in_stall_dut),
        .o_valid(out_valid), .o_data(out_data), .i_stall(out_stall),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Behavioral copy of the table.
    logic               tbl_valid [NSLOT];
    logic [31:0]        tbl_key   [NSLOT];
    longint             tbl_age   [NSLOT];
    int unsigned        tbl_count;
    longint             rel_num;
    logic [4:0]         limit_reg;

    t_out   resp_queue [$];
    int     errors = 0;
    int     accepted_in = 0;
    int     accepted_out = 0;
    int     idle_in_pct = 0;
    int     stall_out_pct = 0;
    bit     long_hold = 1'b0;
    int     wdog = 0;

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic t_out cache_predict(t_in req);
        t_out r;
        int s;
        int f;
        int vic;
        r = '0;
        if (req.cmd == CMD_GET) begin
            s = find_slot(req.key);
            if (s >= 0) begin
                if (tbl_age[s] > 0) begin
                    if (tbl_age[s] < 64'sd2147483647) tbl_age[s]++;
                end else begin
                    tbl_age[s] = 1;
                end
                r.status = ST_HIT;
                r.handle_out = s[3:0];
            end else if (!req.create_ok) begin
                r.status = ST_CREATE_NG;
            end else begin
                f = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!tbl_valid[i] && f < 0) f = i;
                if (f < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_valid[f] = 1'b1;
                    tbl_key[f] = req.key;
                    tbl_age[f] = 1;
                    tbl_count++;
                    r.status = ST_INSERTED;
                    r.handle_out = f[3:0];
                    while (tbl_count > limit_reg) begin
                        vic = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (tbl_valid[i] && tbl_age[i] <= 0 &&
                                (vic < 0 || tbl_age[vic] < tbl_age[i])) vic = i;
                        if (vic < 0) break;
                        tbl_valid[vic] = 1'b0;
                        tbl_count--;
                        r.evicted_count++;
                    end
                end
            end
        end else if (req.cmd == CMD_RELEASE) begin
            r.handle_out = req.handle;
            if (!tbl_valid[req.handle]) begin
                r.status = ST_REL_EMPTY;
            end else begin
                if (tbl_age[req.handle] > 1) begin
                    tbl_age[req.handle]--;
                end else begin
                    if (rel_num < 64'sd2147483647) rel_num++;
                    tbl_age[req.handle] = -rel_num;
                end
                r.status = ST_RELEASED;
            end
        end else begin
            s = find_slot(req.key);
            if (s >= 0) begin
                r.status = ST_PRESENT;
                r.handle_out = s[3:0];
            end else begin
                r.status = ST_ABSENT;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch on response %0d: %s got %0d expected %0d",
                 accepted_out, what, got, want);
    endtask

    // Response checker.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            t_out want;
            if (resp_queue.size() == 0) begin
                report_mismatch("unexpected response, status", out_data.status, -1);
            end else begin
                want = resp_queue.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.handle_out !== want.handle_out)
                    report_mismatch("handle_out", out_data.handle_out, want.handle_out);
                if (out_data.evicted_count !== want.evicted_count)
                    report_mismatch("evicted_count", out_data.evicted_count,
                                    want.evicted_count);
            end
            accepted_out++;
        end
    end

    // Receiver stall, forced high for the long hold-off while long_hold is set.
    always @(posedge clk) begin
        if (long_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_out_pct);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if ((in_valid && !in_stall_dut) || (out_valid && !out_stall) || long_hold)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d responses pending", resp_queue.size());
            $display("status: fail");
            $finish;
        end
    end

    // The valid stays high after acceptance until the next call or a drain
    // lowers it; the block is busy by then, so nothing is taken twice.
    task automatic send_req(t_in req);
        while ($urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall_dut) @(posedge clk);
        resp_queue.push_back(cache_predict(req));
        accepted_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (resp_queue.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limit(logic [4:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = v;
    endtask

    function automatic t_in mk(logic [1:0] c, logic [31:0] k, logic ok, logic [3:0] h);
        t_in r;
        r.cmd = c; r.key = k; r.create_ok = ok; r.handle = h;
        return r;
    endfunction

    // A small key pool keeps hits and releases frequent.
    function automatic t_in rand_req(int pool);
        t_in r;
        int p;
        p = $urandom_range(99);
        r.key = ($urandom_range(9) == 0) ? $urandom()
                : 32'(($urandom_range(pool - 1)) * 32'h1F0F_0F01);
        r.create_ok = ($urandom_range(9) != 0);
        r.handle = $urandom_range(15);
        if (p < 45) r.cmd = CMD_GET;
        else if (p < 85) r.cmd = CMD_RELEASE;
        else if (p < 97) r.cmd = CMD_QUERY;
        else r.cmd = CMD_UNUSED;
        return r;
    endfunction

    typedef struct {
        t_in  req;
        bit   has_want;
        t_out want;
    } t_row;

    t_row rows [$];

    initial begin
        t_out g;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_age[i] = 0;
        end
        tbl_count = 0; rel_num = 0; limit_reg = SIZE_LIMIT_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; known responses only where obvious.
        rows.push_back('{mk(CMD_QUERY, 32'h0, 1'b0, 4'd0), 1, '{ST_ABSENT, 4'd0, 5'd0}});
        rows.push_back('{mk(CMD_RELEASE, 32'h0, 1'b0, 4'd15), 1, '{ST_REL_EMPTY, 4'd15, 5'd0}});
        rows.push_back('{mk(CMD_GET, 32'hFFFF_FFFF, 1'b0, 4'd0), 1, '{ST_CREATE_NG, 4'd0, 5'd0}});
        rows.push_back('{mk(CMD_GET, 32'hFFFF_FFFF, 1'b1, 4'd0), 1, '{ST_INSERTED, 4'd0, 5'd0}});
        rows.push_back('{mk(CMD_GET, 32'h0, 1'b1, 4'd0), 1, '{ST_INSERTED, 4'd1, 5'd0}});
        rows.push_back('{mk(CMD_GET, 32'hFFFF_FFFF, 1'b1, 4'd0), 1, '{ST_HIT, 4'd0, 5'd0}});
        rows.push_back('{mk(CMD_UNUSED, 32'h0, 1'b0, 4'd0), 1, '{ST_PRESENT, 4'd1, 5'd0}});
        rows.push_back('{mk(CMD_RELEASE, 32'h0, 1'b1, 4'd0), 1, '{ST_RELEASED, 4'd0, 5'd0}});
        rows.push_back('{mk(CMD_RELEASE, 32'h0, 1'b1, 4'd0), 0, '0});
        rows.push_back('{mk(CMD_RELEASE, 32'h0, 1'b1, 4'd0), 0, '0});
        rows.push_back('{mk(CMD_RELEASE, 32'h0, 1'b1, 4'd1), 0, '0});
        for (int i = 2; i < NSLOT; i++)
            rows.push_back('{mk(CMD_GET, 32'(i) << 20, 1'b1, 4'd0), 0, '0});
        rows.push_back('{mk(CMD_GET, 32'hA5A5_5A5A, 1'b1, 4'd0), 1, '{ST_FULL, 4'd0, 5'd0}});
        foreach (rows[n]) begin
            send_req(rows[n].req);
            if (rows[n].has_want) begin
                g = resp_queue[$];
                if (g != rows[n].want)
                    report_mismatch("directed row predictor", n, -1);
            end
        end

        // Limit 0 on a full table: a new key is refused, so nothing is evicted.
        set_limit(5'd0);
        send_req(mk(CMD_GET, 32'h1234_5678, 1'b1, 4'd0));
        send_req(mk(CMD_GET, 32'h1234_5679, 1'b1, 4'd0));

        // Random phases over several limits and idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
                1: begin idle_in_pct = 59; stall_out_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_out_pct = 59; end
                default: begin idle_in_pct = 26; stall_out_pct = 26; end
            endcase
            set_limit((ph == 0) ? 5'd16 : (ph == 4) ? 5'd31 : (ph == 7) ? 5'd1
                      : 5'($urandom_range(16)));
            if (ph == 2) begin
                fork
                    begin
                        long_hold <= 1'b1;
                        repeat (400) @(posedge clk);
                        long_hold <= 1'b0;
                    end
                    for (int n = 0; n < 10; n++) send_req(rand_req(20));
                join
            end
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                send_req(rand_req((ph % 2) ? 12 : 24));
                if (n == 60 && ph == 5) drain();
            end
        end
        drain();
        $display("covered %0d requests over eight phases, size limits 0 to 31,", accepted_in);
        $display("idle and stall mixes, a long receiver hold-off and %0d releases stamped",
                 rel_num);
        if (errors == 0 && resp_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
